// File: rtl/core/edpdc_pkg.sv
`timescale 1ns / 1ps

package edpdc_pkg;

   localparam int unsigned FeBits = 256;

   // field prime 2^255 - 19 and curve constants
   localparam logic [FeBits-1:0] FeP =
      256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
   localparam logic [FeBits-1:0] FeD =
      256'h52036cee2b6ffe738cc740797779e89800700a4d4141d8ab75eb4dca135978a3;
   localparam logic [FeBits-1:0] FeSqrtM1 =
      256'h2b8324804fc1df0b2b4d00993dfbd7a72f431806ad2fe478c4ee1b274a0ea0b0;
   localparam logic [FeBits-1:0] FeOne  = 256'd1;
   localparam logic [FeBits-1:0] FeZero = 256'd0;

   // verdict codes
   localparam logic [1:0] REASON_OK      = 2'd0;
   localparam logic [1:0] REASON_NONCANON = 2'd1;
   localparam logic [1:0] REASON_NOROOT  = 2'd2;
   localparam logic [1:0] REASON_SIGN    = 2'd3;

   // operation codes of the sequencer program
   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2,
      OP_CMP = 2'd3
   } op_type;

   // scratch entries
   localparam logic [3:0] S_Y2  = 4'd0;
   localparam logic [3:0] S_U   = 4'd1;
   localparam logic [3:0] S_V   = 4'd2;
   localparam logic [3:0] S_V2  = 4'd3;
   localparam logic [3:0] S_V3  = 4'd4;
   localparam logic [3:0] S_UV3 = 4'd5;
   localparam logic [3:0] S_V7  = 4'd6;
   localparam logic [3:0] S_UV7 = 4'd7;
   localparam logic [3:0] S_ACC = 4'd8;
   localparam logic [3:0] S_R   = 4'd9;
   localparam logic [3:0] S_CHK = 4'd10;
   localparam logic [3:0] S_NU  = 4'd11;

   // flag slots for compare results
   localparam logic [3:0] F_PLAIN = 4'd0;
   localparam logic [3:0] F_FLIP  = 4'd1;
   localparam logic [3:0] F_ZERO  = 4'd2;

   // operand sources: scratch entries below 16, constants and the input y from 16 up
   localparam logic [4:0] A_Y2   = {1'b0, S_Y2};
   localparam logic [4:0] A_U    = {1'b0, S_U};
   localparam logic [4:0] A_V    = {1'b0, S_V};
   localparam logic [4:0] A_V2   = {1'b0, S_V2};
   localparam logic [4:0] A_V3   = {1'b0, S_V3};
   localparam logic [4:0] A_UV3  = {1'b0, S_UV3};
   localparam logic [4:0] A_V7   = {1'b0, S_V7};
   localparam logic [4:0] A_UV7  = {1'b0, S_UV7};
   localparam logic [4:0] A_ACC  = {1'b0, S_ACC};
   localparam logic [4:0] A_R    = {1'b0, S_R};
   localparam logic [4:0] A_CHK  = {1'b0, S_CHK};
   localparam logic [4:0] A_NU   = {1'b0, S_NU};
   localparam logic [4:0] A_ONE  = 5'd16;
   localparam logic [4:0] A_D    = 5'd17;
   localparam logic [4:0] A_SQM1 = 5'd18;
   localparam logic [4:0] A_Y    = 5'd19;
   localparam logic [4:0] A_ZERO = 5'd20;

   typedef struct packed {
      op_type     op;
      logic [3:0] dst;
      logic [4:0] srca;
      logic [4:0] srcb;
   } instr_type;

   // program counters with special meaning
   localparam logic [4:0] PC_LOOP_SQ  = 5'd11;
   localparam logic [4:0] PC_LOOP_MUL = 5'd12;
   localparam logic [4:0] PC_LAST     = 5'd19;
   localparam logic [7:0] EXP_TOP_BIT = 8'd251;

   // sequencer program: u, v, v^3, v^7, power chain, check
   function automatic instr_type prog(input logic [4:0] pc);
      instr_type ins;
      case (pc)
         5'd0:  ins = '{OP_MUL, S_Y2,  A_Y,    A_Y};
         5'd1:  ins = '{OP_SUB, S_U,   A_Y2,   A_ONE};
         5'd2:  ins = '{OP_MUL, S_V,   A_Y2,   A_D};
         5'd3:  ins = '{OP_ADD, S_V,   A_V,    A_ONE};
         5'd4:  ins = '{OP_MUL, S_V2,  A_V,    A_V};
         5'd5:  ins = '{OP_MUL, S_V3,  A_V2,   A_V};
         5'd6:  ins = '{OP_MUL, S_UV3, A_U,    A_V3};
         5'd7:  ins = '{OP_MUL, S_V7,  A_V3,   A_V3};
         5'd8:  ins = '{OP_MUL, S_V7,  A_V7,   A_V};
         5'd9:  ins = '{OP_MUL, S_UV7, A_U,    A_V7};
         5'd10: ins = '{OP_ADD, S_ACC, A_ONE,  A_ZERO};
         5'd11: ins = '{OP_MUL, S_ACC, A_ACC,  A_ACC};
         5'd12: ins = '{OP_MUL, S_ACC, A_ACC,  A_UV7};
         5'd13: ins = '{OP_MUL, S_R,   A_ACC,  A_UV3};
         5'd14: ins = '{OP_MUL, S_CHK, A_R,    A_R};
         5'd15: ins = '{OP_MUL, S_CHK, A_CHK,  A_V};
         5'd16: ins = '{OP_SUB, S_NU,  A_ZERO, A_U};
         5'd17: ins = '{OP_CMP, F_PLAIN, A_CHK, A_U};
         5'd18: ins = '{OP_CMP, F_FLIP,  A_CHK, A_NU};
         5'd19: ins = '{OP_CMP, F_ZERO,  A_R,   A_ZERO};
         default: ins = '{OP_CMP, F_ZERO, A_ZERO, A_ZERO};
      endcase
      return ins;
   endfunction

   // status from sequencer to top level
   typedef struct packed {
      logic done;
      logic root_ok;
      logic x_zero;
   } seq_stat_type;

endpackage

// File: rtl/core/edpdc_mul.sv
`timescale 1ns / 1ps

module edpdc_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [255:0] a,
   input  logic [255:0] b,
   output logic         done,
   output logic [255:0] r
);

   localparam int unsigned AccBits = 72;

   typedef enum logic [2:0] {
      M_IDLE, M_PROD, M_DRAIN, M_LAST, M_RED, M_FOLD, M_CANON
   } mstate_type;

   mstate_type         state_ff;
   logic [255:0]       a_ff, b_ff, o_ff, f_ff, r_ff;
   logic [511:0]       t_ff;
   logic [3:0]         k_ff;
   logic [2:0]         i_ff, cnt_ff;
   logic [63:0]        prod_ff;
   logic               tag_ff, pv_ff, done_ff;
   logic [AccBits-1:0] acc_ff;
   logic [7:0]         c_ff;

   logic [3:0]         j_in;
   logic [31:0]        a_limb, b_limb;
   logic [2:0]         i_hi, i_lo_next;
   logic [3:0]         k_next;
   logic [AccBits-1:0] sum;
   logic [39:0]        red_s;
   logic [8:0]         fold_top;
   logic [13:0]        fold_c;
   logic [255:0]       fold_v;
   logic [256:0]       canon_d;

   // limb selection for column-wise product scan
   always_comb begin
      j_in      = k_ff - {1'b0, i_ff};
      a_limb    = a_ff[{i_ff, 5'd0} +: 32];
      b_limb    = b_ff[{j_in[2:0], 5'd0} +: 32];
      i_hi      = (k_ff < 4'd7) ? k_ff[2:0] : 3'd7;
      k_next    = k_ff + 4'd1;
      i_lo_next = (k_next > 4'd7) ? 3'(k_next - 4'd7) : 3'd0;
   end

   // column accumulate, reduction by 38, fold by 19, final subtract
   always_comb begin
      sum      = acc_ff + {8'd0, prod_ff};
      red_s    = {8'd0, t_ff[31:0]} + 40'(t_ff[287:256]) * 40'd38 + {32'd0, c_ff};
      fold_top = {c_ff, o_ff[255]};
      fold_c   = 14'(fold_top) * 14'd19;
      fold_v   = {1'b0, o_ff[254:0]} + {242'd0, fold_c};
      canon_d  = {1'b0, f_ff} - {1'b0, edpdc_pkg::FeP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         pv_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         // product pipeline into column accumulator
         if (pv_ff) begin
            if (tag_ff) begin
               t_ff   <= {sum[31:0], t_ff[511:32]};
               acc_ff <= sum >> 32;
            end else begin
               acc_ff <= sum;
            end
         end
         case (state_ff)
            M_IDLE: begin
               pv_ff <= 1'b0;
               if (start) begin
                  a_ff     <= a;
                  b_ff     <= b;
                  k_ff     <= 4'd0;
                  i_ff     <= 3'd0;
                  acc_ff   <= '0;
                  state_ff <= M_PROD;
               end
            end
            M_PROD: begin
               prod_ff <= a_limb * b_limb;
               tag_ff  <= (i_ff == i_hi);
               pv_ff   <= 1'b1;
               if (i_ff == i_hi) begin
                  if (k_ff == 4'd14) begin
                     state_ff <= M_DRAIN;
                  end else begin
                     k_ff <= k_next;
                     i_ff <= i_lo_next;
                  end
               end else begin
                  i_ff <= i_ff + 3'd1;
               end
            end
            M_DRAIN: begin
               pv_ff    <= 1'b0;
               state_ff <= M_LAST;
            end
            M_LAST: begin
               t_ff     <= {acc_ff[31:0], t_ff[511:32]};
               cnt_ff   <= 3'd0;
               c_ff     <= 8'd0;
               state_ff <= M_RED;
            end
            M_RED: begin
               o_ff   <= {red_s[31:0], o_ff[255:32]};
               c_ff   <= red_s[39:32];
               t_ff   <= {32'd0, t_ff[511:288], 32'd0, t_ff[255:32]};
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_ff <= M_FOLD;
               end
            end
            M_FOLD: begin
               f_ff     <= fold_v;
               state_ff <= M_CANON;
            end
            M_CANON: begin
               r_ff     <= canon_d[256] ? f_ff : canon_d[255:0];
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign r    = r_ff;

endmodule

// File: rtl/core/edpdc_seq.sv
`timescale 1ns / 1ps

module edpdc_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [254:0]            y,
   output edpdc_pkg::seq_stat_type stat
);

   typedef enum logic [2:0] {
      Q_IDLE, Q_FETCH, Q_EXEC, Q_WAITM, Q_ASTEP
   } qstate_type;

   qstate_type           state_ff;
   logic [4:0]           pc_ff;
   logic [7:0]           bit_ff;
   logic [2:0]           flag_ff;
   logic                 done_ff;
   logic [255:0]         scratch_mem [16];
   logic [255:0]         rda_ff, rdb_ff;
   logic [256:0]         s1_ff;
   logic                 mstart;
   logic                 mdone;
   logic [255:0]         mres;

   edpdc_pkg::instr_type ins;
   logic [255:0]         opa, opb;
   logic [256:0]         add_d, sub_d;
   logic [255:0]         astep_res;
   logic                 wr_en;
   logic [255:0]         wr_data;

   function automatic logic [255:0] pick(input logic [4:0] src, input logic [255:0] mdat,
                                         input logic [254:0] yv);
      logic [255:0] v;
      case (src)
         edpdc_pkg::A_ONE:  v = edpdc_pkg::FeOne;
         edpdc_pkg::A_D:    v = edpdc_pkg::FeD;
         edpdc_pkg::A_SQM1: v = edpdc_pkg::FeSqrtM1;
         edpdc_pkg::A_Y:    v = {1'b0, yv};
         edpdc_pkg::A_ZERO: v = edpdc_pkg::FeZero;
         default:           v = src[4] ? edpdc_pkg::FeZero : mdat;
      endcase
      return v;
   endfunction

   // current instruction and its operands
   always_comb begin
      ins   = edpdc_pkg::prog(pc_ff);
      opa   = pick(ins.srca, rda_ff, y);
      opb   = pick(ins.srcb, rdb_ff, y);
      add_d = s1_ff - {1'b0, edpdc_pkg::FeP};
      sub_d = s1_ff + {1'b0, edpdc_pkg::FeP};
      if (ins.op == edpdc_pkg::OP_ADD) begin
         astep_res = add_d[256] ? s1_ff[255:0] : add_d[255:0];
      end else begin
         astep_res = s1_ff[256] ? sub_d[255:0] : s1_ff[255:0];
      end
   end

   // scratch write back
   always_comb begin
      wr_en   = ((state_ff == Q_WAITM) && mdone) || (state_ff == Q_ASTEP);
      wr_data = (state_ff == Q_ASTEP) ? astep_res : mres;
   end

   // scratch memory, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         scratch_mem[ins.dst] <= wr_data;
      end
      rda_ff <= scratch_mem[ins.srca[3:0]];
      rdb_ff <= scratch_mem[ins.srcb[3:0]];
   end

   assign mstart = (state_ff == Q_EXEC) && (ins.op == edpdc_pkg::OP_MUL);

   edpdc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mstart),
      .a     (opa),
      .b     (opb),
      .done  (mdone),
      .r     (mres)
   );

   // program sequencer with exponent loop
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
         pc_ff    <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            Q_IDLE: begin
               if (start) begin
                  pc_ff    <= 5'd0;
                  bit_ff   <= edpdc_pkg::EXP_TOP_BIT;
                  state_ff <= Q_FETCH;
               end
            end
            Q_FETCH: state_ff <= Q_EXEC;
            Q_EXEC: begin
               case (ins.op)
                  edpdc_pkg::OP_MUL: state_ff <= Q_WAITM;
                  edpdc_pkg::OP_ADD: begin
                     s1_ff    <= {1'b0, opa} + {1'b0, opb};
                     state_ff <= Q_ASTEP;
                  end
                  edpdc_pkg::OP_SUB: begin
                     s1_ff    <= {1'b0, opa} - {1'b0, opb};
                     state_ff <= Q_ASTEP;
                  end
                  default: begin
                     flag_ff[ins.dst[1:0]] <= (opa == opb);
                     if (pc_ff == edpdc_pkg::PC_LAST) begin
                        done_ff  <= 1'b1;
                        state_ff <= Q_IDLE;
                     end else begin
                        pc_ff    <= pc_ff + 5'd1;
                        state_ff <= Q_FETCH;
                     end
                  end
               endcase
            end
            Q_WAITM: begin
               if (mdone) begin
                  state_ff <= Q_FETCH;
                  if (pc_ff == edpdc_pkg::PC_LOOP_SQ) begin
                     // exponent bit 1 is clear: skip the multiply
                     if (bit_ff == 8'd1) begin
                        bit_ff <= 8'd0;
                     end else begin
                        pc_ff <= edpdc_pkg::PC_LOOP_MUL;
                     end
                  end else if (pc_ff == edpdc_pkg::PC_LOOP_MUL) begin
                     if (bit_ff == 8'd0) begin
                        pc_ff <= pc_ff + 5'd1;
                     end else begin
                        bit_ff <= bit_ff - 8'd1;
                        pc_ff  <= edpdc_pkg::PC_LOOP_SQ;
                     end
                  end else begin
                     pc_ff <= pc_ff + 5'd1;
                  end
               end
            end
            Q_ASTEP: begin
               pc_ff    <= pc_ff + 5'd1;
               state_ff <= Q_FETCH;
            end
            default: state_ff <= Q_IDLE;
         endcase
      end
   end

   always_comb begin
      stat.done    = done_ff;
      stat.root_ok = flag_ff[edpdc_pkg::F_PLAIN[1:0]] | flag_ff[edpdc_pkg::F_FLIP[1:0]];
      stat.x_zero  = flag_ff[edpdc_pkg::F_ZERO[1:0]];
   end

endmodule

// File: rtl/core/ed25519_point_decompress_check_unit.sv
`timescale 1ns / 1ps

// Ed25519 point decompression check.
// req_ channel: four 64-bit words of the encoded point, least significant
// word first; req_tlast marks the final word. An early tlast treats the
// missing high words as zero; four words without tlast start a new point.
// rsp_ channel: one word per point, sent after the word carrying tlast:
// on_curve and a reject reason (0 ok, 1 y not canonical, 2 no root,
// 3 sign unsatisfiable).
// Words are taken one per cycle while collecting. A non-canonical y is
// answered from the check state without running the sequencer. Otherwise
// the check runs 514 field multiplications on one serial 32x32 multiplier,
// plus instruction fetch overhead. Most of those multiplications form the
// square-and-multiply chain through the scratch memory.
// One point is in work at a time; the next point's words are taken while a
// result waits in the output register.
// Reset clears the word count, sequencer and output valid; scratch memory
// needs no clearing. A stalled receiver holds the result word and the block
// waits with its next verdict until the output register frees.
module ed25519_point_decompress_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] key_word
   input  logic        req_tlast,   // word_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] on_curve, [2:1] reject_reason, [7:3] zero
);

   typedef enum logic [1:0] {
      T_COLLECT, T_CHECK, T_RUN, T_DONE
   } tstate_type;

   tstate_type              state_ff;
   logic [1:0]              idx_ff;
   logic [63:0]             words_ff [4];
   logic [1:0]              reason_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_reason_ff;
   logic                    seq_start;
   edpdc_pkg::seq_stat_type stat;

   logic                    take;
   logic [254:0]            y;
   logic                    sign;
   logic                    noncanon;

   always_comb begin
      take     = req_tvalid && req_tready;
      y        = {words_ff[3][62:0], words_ff[2], words_ff[1], words_ff[0]};
      sign     = words_ff[3][63];
      noncanon = ({1'b0, y} >= edpdc_pkg::FeP);
   end

   assign req_tready = (state_ff == T_COLLECT);
   assign seq_start  = (state_ff == T_CHECK) && !noncanon;

   edpdc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (seq_start),
      .y     (y),
      .stat  (stat)
   );

   // word slots, high ones zeroed on early last
   always_ff @(posedge clock) begin
      for (int s = 0; s < 4; s++) begin
         if (take) begin
            if (idx_ff == 2'(s)) begin
               words_ff[s] <= req_tdata;
            end else if (req_tlast && (2'(s) > idx_ff)) begin
               words_ff[s] <= 64'd0;
            end
         end
      end
   end

   // collect, check and output control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_COLLECT;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output word leaves unless a new verdict replaces it
         if (rsp_valid_ff && rsp_tready && (state_ff != T_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_COLLECT: begin
               if (take) begin
                  if (req_tlast) begin
                     idx_ff   <= 2'd0;
                     state_ff <= T_CHECK;
                  end else begin
                     idx_ff <= idx_ff + 2'd1;
                  end
               end
            end
            T_CHECK: begin
               if (noncanon) begin
                  reason_ff <= edpdc_pkg::REASON_NONCANON;
                  state_ff  <= T_DONE;
               end else begin
                  state_ff <= T_RUN;
               end
            end
            T_RUN: begin
               if (stat.done) begin
                  if (!stat.root_ok) begin
                     reason_ff <= edpdc_pkg::REASON_NOROOT;
                  end else if (sign && stat.x_zero) begin
                     reason_ff <= edpdc_pkg::REASON_SIGN;
                  end else begin
                     reason_ff <= edpdc_pkg::REASON_OK;
                  end
                  state_ff <= T_DONE;
               end
            end
            T_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_reason_ff <= reason_ff;
                  state_ff      <= T_COLLECT;
               end
            end
            default: state_ff <= T_COLLECT;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_reason_ff, (rsp_reason_ff == edpdc_pkg::REASON_OK)};

endmodule
